@@ sv/kfi_pkg.sv @@
// Shared types, constants and helper functions for the keyframe spectrum interpolator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kfi_pkg;
    localparam int KF      = 16;
    localparam int KF_W    = 4;
    localparam int FREQS   = 64;
    localparam int FREQ_W  = 6;
    localparam int MAG_W   = 16;
    localparam int TIME_W  = 16;
    localparam int ADDR_W  = KF_W + FREQ_W;
    localparam int DIV_NW  = 32;
    localparam int DIV_DW  = 17;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    localparam logic [TIME_W-1:0] DUR_RESET = 16'd1000;

    // keyframe time k*D/(KF-1) by reciprocal multiply: ceil(2^24/15) is exact
    // for every k*D below 2^20
    localparam int KT_W     = KF_W + TIME_W;
    localparam int KT_RCP_W = 21;
    localparam int KT_SHIFT = 24;
    localparam logic [KT_RCP_W-1:0] KT_RCP = 21'd1118482;

    typedef enum logic [1:0] {
        F_SET_TIME = 2'd0,
        F_SET_MAG  = 2'd1,
        F_GET_MAG  = 2'd2,
        F_DEL_KEY  = 2'd3
    } t_func;

    localparam logic [1:0] CFG_DURATION = 2'd0;
    localparam logic [1:0] CFG_LOCK     = 2'd1;

    typedef struct packed {
        logic              go;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic            ok;
        logic [KF_W-1:0] idx;
    } t_nb;

    // nearest active keyframe below c
    function automatic t_nb prev_active(input logic [KF-1:0] flags, input logic [KF_W-1:0] c);
        t_nb res;
        res = '0;
        for (int j = 0; j < KF; j++) begin
            if (KF_W'(j) < c && flags[j]) begin
                res.ok  = 1'b1;
                res.idx = KF_W'(j);
            end
        end
        return res;
    endfunction

    // nearest active keyframe above c
    function automatic t_nb next_active(input logic [KF-1:0] flags, input logic [KF_W-1:0] c);
        t_nb res;
        res = '0;
        for (int j = KF - 1; j >= 0; j--) begin
            if (KF_W'(j) > c && flags[j]) begin
                res.ok  = 1'b1;
                res.idx = KF_W'(j);
            end
        end
        return res;
    endfunction
endpackage
`default_nettype wire

@@ sv/kfi_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kfi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ sv/kfi_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Depends on kfi_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kfi_div
    import kfi_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);
    logic                      r_run;
    logic                      r_done;
    logic [$clog2(DIV_NW)-1:0] r_cnt;
    logic [DIV_DW-1:0]         r_rem;
    logic [DIV_NW-1:0]         r_quo;
    logic [DIV_DW-1:0]         r_den;
    logic [DIV_DW:0]           w_trial;
    logic                      w_ge;

    assign w_trial = {r_rem, r_quo[DIV_NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_req.go && r_run && (r_cnt == $clog2(DIV_NW)'(DIV_NW - 1));
            if (i_req.go) begin
                r_run <= 1'b1;
                r_cnt <= '0;
                r_rem <= '0;
                r_quo <= i_req.num;
                r_den <= i_req.den;
            end else if (r_run) begin
                r_rem <= w_ge ? DIV_DW'(w_trial - {1'b0, r_den}) : w_trial[DIV_DW-1:0];
                r_quo <= {r_quo[DIV_NW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == $clog2(DIV_NW)'(DIV_NW - 1)) begin
                    r_run <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;
endmodule
`default_nettype wire

@@ sv/keyframe_spectrum_interpolator.sv @@
// Keyframe spectrum interpolator, top level: sequencer around one shared divider.
// set_time and delete hold busy through one select divide.
// get_magnitude: result the cycle after accept when invalid, else busy through the target
// keyframe time and, with both neighbours, their keyframe times and one interpolation divide.
// set_magnitude: a single write on an active keyframe; a new row is first zero-filled or
// filled with 64 interpolated bins. A new item is taken while busy is low. Sync reset.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_spectrum_interpolator
    import kfi_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [1:0]        i_func,
    input  wire logic [TIME_W-1:0] i_time_value,
    input  wire logic [FREQ_W-1:0] i_freq_index,
    input  wire logic [MAG_W-1:0]  i_magnitude_in,
    output logic                   o_valid,
    output logic [MAG_W-1:0]       o_magnitude_out,
    output logic                   o_keyframe_valid,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data
);
    typedef enum logic [4:0] {
        S_IDLE, S_SEL_GO, S_SEL_WAIT, S_TT_GO, S_TT_WAIT, S_NB,
        S_LT_GO, S_LT_WAIT, S_RT_GO, S_RT_WAIT, S_BIN, S_RDR, S_RV,
        S_MUL, S_DIV_GO, S_DIV_WAIT, S_SAT, S_DONE_BIN, S_FILL_Z, S_ACT, S_WR
    } t_state;

    t_state r_state;

    // configuration and timeline state
    logic [TIME_W-1:0] r_dur;
    logic              r_lock;
    logic [TIME_W-1:0] r_time;
    logic [KF_W-1:0]   r_kf;
    logic              r_kfv;
    logic [KF-1:0]     r_act;
    logic              r_zero0;   // row 0 still holds its reset zeros, RAM not written

    // latched item
    t_func             r_func;
    logic [TIME_W-1:0] r_tv;
    logic [FREQ_W-1:0] r_fi;
    logic [MAG_W-1:0]  r_mag;

    // interpolation working set
    logic [KF_W-1:0]   r_tgt;
    t_nb               r_l, r_r;
    logic [TIME_W-1:0] r_tt, r_lt, r_rt, r_d, r_dt;
    logic              r_tneg, r_dneg, r_neg;
    logic [FREQ_W-1:0] r_bin;
    logic [MAG_W-1:0]  r_lv, r_dm, r_val;
    logic [2*MAG_W-1:0] r_prod;
    logic [DIV_NW:0]   r_q;
    logic [KT_W-1:0]   r_ktn;     // k*D for the keyframe time in progress

    // result
    logic              r_strobe;
    logic [MAG_W-1:0]  r_out_mag;
    logic              r_out_kv;

    // datapath wires
    logic [TIME_W-1:0] w_dur;
    t_nb               w_prev, w_next, w_l, w_r, w_kf_prev;
    logic [KF_W-1:0]   w_first, w_rrow;
    logic [MAG_W-1:0]  w_rd, w_rdm;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr, w_raddr;
    logic [MAG_W-1:0]  w_wdata;
    logic              w_fi_ok;
    logic [MAG_W:0]    w_sum;
    logic [KF_W-1:0]   w_kt_idx;
    logic [KT_W-1:0]   w_ktn;
    logic [KT_W+KT_RCP_W-1:0] w_kt_prod;
    logic [TIME_W-1:0] w_kt;
    logic              w_get_now;
    logic              w_strobe;
    t_div_req          w_req;
    t_div_rsp          w_rsp;

    assign w_dur     = (r_dur == '0) ? TIME_W'(1) : r_dur;
    assign w_prev    = prev_active(r_act, r_tgt);
    assign w_next    = next_active(r_act, r_tgt);
    assign w_kf_prev = prev_active(r_act, r_kf);
    assign w_first   = r_l.ok ? r_l.idx : r_r.idx;
    assign w_rrow    = (r_state == S_RV) ? r_r.idx : w_first;
    // row 0 reads as zero until it is first filled
    assign w_rdm     = (w_rrow == '0 && r_zero0) ? '0 : w_rd;
    assign w_fi_ok   = {1'b0, r_fi} < (FREQ_W + 1)'(FREQS);
    assign w_sum     = {1'b0, r_q[MAG_W-1:0]} + {1'b0, r_lv};

    // keyframe time T(k) = floor(k*D/(KF-1)): product in the GO cycle,
    // reciprocal multiply in the following one
    assign w_kt_idx  = (r_state == S_TT_GO) ? r_tgt :
                       (r_state == S_LT_GO) ? r_l.idx : r_r.idx;
    assign w_ktn     = KT_W'(w_kt_idx) * KT_W'(w_dur);
    assign w_kt_prod = (KT_W + KT_RCP_W)'(r_ktn) * (KT_W + KT_RCP_W)'(KT_RCP);
    assign w_kt      = w_kt_prod[KT_SHIFT +: TIME_W];

    // invalid keyframe or bin out of range: answered straight from idle
    assign w_get_now = start && (t_func'(i_func) == F_GET_MAG)
                     && (!r_kfv || {1'b0, i_freq_index} >= (FREQ_W + 1)'(FREQS));
    assign w_strobe  = (r_state == S_IDLE && w_get_now)
                     || (r_state == S_DONE_BIN && r_func == F_GET_MAG);

    // neighbours of the target keyframe
    always_comb begin
        w_l = w_prev;
        w_r = w_next;
        if (r_act[r_tgt]) begin
            if (r_time < r_tt) begin
                w_r = '{ok: 1'b1, idx: r_tgt};
            end else begin
                w_l = '{ok: 1'b1, idx: r_tgt};
            end
        end
    end

    // divider requests
    always_comb begin
        w_req = '{go: 1'b0, num: '0, den: DIV_DW'(1)};
        unique case (r_state)
            S_SEL_GO: begin
                // round half up of t*(KF-1)/D
                w_req.go  = 1'b1;
                w_req.num = DIV_NW'(r_tv) * DIV_NW'(2 * (KF - 1)) + DIV_NW'(w_dur);
                w_req.den = {w_dur, 1'b0};
            end
            S_DIV_GO: begin
                w_req.go  = 1'b1;
                w_req.num = r_prod;
                w_req.den = DIV_DW'(r_d);
            end
            default: ;
        endcase
    end

    // magnitude store ports
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_kf, r_bin};
        w_wdata = '0;
        unique case (r_state)
            S_DONE_BIN: begin
                w_we    = (r_func != F_GET_MAG);
                w_wdata = r_val;
            end
            S_FILL_Z: w_we = 1'b1;
            S_WR: begin
                w_we    = w_fi_ok;
                w_waddr = {r_kf, r_fi};
                w_wdata = r_mag;
            end
            default: ;
        endcase
    end
    assign w_raddr = (r_state == S_BIN) ? {w_first, r_bin} : {r_r.idx, r_bin};

    kfi_ram #(.WIDTH(MAG_W), .DEPTH(KF * FREQS)) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rd)
    );

    kfi_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dur    <= DUR_RESET;
            r_lock   <= 1'b0;
            r_time   <= '0;
            r_kf     <= '0;
            r_kfv    <= 1'b1;
            r_act    <= KF'(1);
            r_zero0  <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_strobe;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DURATION: r_dur  <= i_cfg_data;
                    CFG_LOCK:     r_lock <= i_cfg_data[0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func <= t_func'(i_func);
                        r_tv   <= i_time_value;
                        r_fi   <= i_freq_index;
                        r_mag  <= i_magnitude_in;
                        r_bin  <= (t_func'(i_func) == F_GET_MAG) ? i_freq_index : '0;
                        unique case (t_func'(i_func))
                            F_SET_TIME, F_DEL_KEY: r_state <= S_SEL_GO;
                            F_SET_MAG: begin
                                if (!r_lock && r_kfv) begin
                                    if (!r_act[r_kf]) begin
                                        // activation: fill with bins interpolated around the previous active keyframe
                                        if (w_kf_prev.ok) begin
                                            r_tgt   <= w_kf_prev.idx;
                                            r_state <= S_TT_GO;
                                        end else begin
                                            r_state <= S_FILL_Z;
                                        end
                                    end else if (r_kf == '0 && r_zero0) begin
                                        r_state <= S_FILL_Z;
                                    end else begin
                                        r_state <= S_WR;
                                    end
                                end
                            end
                            F_GET_MAG: begin
                                if (w_get_now) begin
                                    r_out_mag <= '0;
                                    r_out_kv  <= r_kfv;
                                end else begin
                                    r_tgt   <= r_kf;
                                    r_state <= S_TT_GO;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SEL_GO: r_state <= S_SEL_WAIT;
                S_SEL_WAIT: begin
                    if (w_rsp.done) begin
                        if (r_func == F_SET_TIME) begin
                            r_time <= r_tv;
                            r_kf   <= w_rsp.quo[KF_W-1:0];
                            r_kfv  <= (w_rsp.quo[DIV_NW-1:KF_W] == '0);
                        end else if (w_rsp.quo[DIV_NW-1:KF_W] == '0) begin
                            r_act[w_rsp.quo[KF_W-1:0]] <= 1'b0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_TT_GO: begin
                    r_ktn   <= w_ktn;
                    r_state <= S_TT_WAIT;
                end
                S_TT_WAIT: begin
                    r_tt    <= w_kt;
                    r_state <= S_NB;
                end
                S_NB: begin
                    r_l <= w_l;
                    r_r <= w_r;
                    if (!w_l.ok && !w_r.ok) begin
                        r_val   <= '0;
                        r_state <= S_DONE_BIN;
                    end else if (w_l.ok && w_r.ok) begin
                        r_state <= S_LT_GO;
                    end else begin
                        r_state <= S_BIN;
                    end
                end
                S_LT_GO: begin
                    r_ktn   <= w_ktn;
                    r_state <= S_LT_WAIT;
                end
                S_LT_WAIT: begin
                    r_lt    <= w_kt;
                    r_state <= S_RT_GO;
                end
                S_RT_GO: begin
                    r_ktn   <= w_ktn;
                    r_tneg  <= r_time < r_lt;
                    r_dt    <= (r_time < r_lt) ? r_lt - r_time : r_time - r_lt;
                    r_state <= S_RT_WAIT;
                end
                S_RT_WAIT: begin
                    r_rt    <= w_kt;
                    r_state <= S_BIN;
                end
                S_BIN: begin
                    r_d     <= r_rt - r_lt;
                    r_state <= S_RDR;
                end
                S_RDR: begin
                    r_lv <= w_rdm;
                    if (!(r_l.ok && r_r.ok) || r_rt <= r_lt) begin
                        r_val   <= w_rdm;
                        r_state <= S_DONE_BIN;
                    end else begin
                        r_state <= S_RV;
                    end
                end
                S_RV: begin
                    r_dneg  <= w_rdm < r_lv;
                    r_dm    <= (w_rdm < r_lv) ? r_lv - w_rdm : w_rdm - r_lv;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= (2 * MAG_W)'(r_dm) * (2 * MAG_W)'(r_dt);
                    r_neg   <= r_dneg ^ r_tneg;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (w_rsp.done) begin
                        // round to nearest, ties away from zero
                        r_q <= {1'b0, w_rsp.quo}
                             + (DIV_NW + 1)'({w_rsp.rem, 1'b0} >= (DIV_DW + 1)'(r_d));
                        r_state <= S_SAT;
                    end
                end
                S_SAT: begin
                    if (r_neg) begin
                        r_val <= (r_q >= (DIV_NW + 1)'(r_lv)) ? '0 : r_lv - r_q[MAG_W-1:0];
                    end else if (r_q[DIV_NW:MAG_W] != '0 || w_sum[MAG_W]) begin
                        r_val <= MAG_MAX;
                    end else begin
                        r_val <= w_sum[MAG_W-1:0];
                    end
                    r_state <= S_DONE_BIN;
                end
                S_DONE_BIN: begin
                    if (r_func == F_GET_MAG) begin
                        r_out_mag <= r_val;
                        r_out_kv  <= 1'b1;
                        r_state   <= S_IDLE;
                    end else if (r_bin == FREQ_W'(FREQS - 1)) begin
                        r_state <= S_ACT;
                    end else begin
                        r_bin   <= r_bin + 1'b1;
                        r_state <= S_BIN;
                    end
                end
                S_FILL_Z: begin
                    if (r_bin == FREQ_W'(FREQS - 1)) begin
                        r_state <= S_ACT;
                    end else begin
                        r_bin <= r_bin + 1'b1;
                    end
                end
                S_ACT: begin
                    r_act[r_kf] <= 1'b1;
                    if (r_kf == '0) begin
                        r_zero0 <= 1'b0;
                    end
                    r_state <= S_WR;
                end
                S_WR: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_strobe;
    assign o_magnitude_out  = r_out_mag;
    assign o_keyframe_valid = r_out_kv;

    // a result is only shown with the sequencer back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result strobe while busy");

    // set_time always runs the select divide
    a_set_time_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_func == F_SET_TIME |=> busy) else $error("set_time not taken");

    // an invalid keyframe answers zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_keyframe_valid |-> o_magnitude_out == '0)
        else $error("nonzero result for invalid keyframe");

    // a divider start is never followed directly by done
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.go |=> !w_rsp.done) else $error("divider done too early");
endmodule
`default_nettype wire
